// ----- rtl/core/sbf_pkg.sv -----
// Shared constants and codes for the sumo robot behaviour controller.
package sbf_pkg;

   localparam int DIST_W        = 16;
   localparam int TIME_W        = 32;
   localparam int CFG_W         = 16;
   localparam int CFG_IDX_W     = 2;
   localparam int MODE_W        = 3;
   localparam int DRIVE_W       = 9;
   localparam int AVG_DEPTH_DEF = 5;

   localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIME   = 2'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_TIME = 2'd1;
   localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_DIST = 2'd2;

   localparam logic [CFG_W-1:0] IDLE_TIME_RST   = 16'd5000;
   localparam logic [CFG_W-1:0] ESCAPE_TIME_RST = 16'd300;
   localparam logic [CFG_W-1:0] ATTACK_DIST_RST = 16'd320;

   localparam logic [MODE_W-1:0] MODE_IDLE      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SEARCH    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ATTACK    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_ESC_FRONT = 3'd3;
   localparam logic [MODE_W-1:0] MODE_ESC_BACK  = 3'd4;

   localparam logic signed [DRIVE_W-1:0] DRIVE_ZERO     = 9'sd0;
   localparam logic signed [DRIVE_W-1:0] DRIVE_SLOW_FWD = 9'sd150;
   localparam logic signed [DRIVE_W-1:0] DRIVE_SLOW_REV = -9'sd150;
   localparam logic signed [DRIVE_W-1:0] DRIVE_FULL_FWD = 9'sd255;
   localparam logic signed [DRIVE_W-1:0] DRIVE_FULL_REV = -9'sd255;

endpackage

// ----- rtl/core/sbf_avg_filter.sv -----
// Moving-average distance filter with exact threshold compare.
module sbf_avg_filter #(
   parameter int AVG_DEPTH = sbf_pkg::AVG_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      update,
   input  logic [sbf_pkg::DIST_W-1:0] distance,
   input  logic [sbf_pkg::CFG_W-1:0]  threshold,
   output logic                      below
);
   import sbf_pkg::*;

   localparam int CNT_W  = $clog2(AVG_DEPTH + 1);
   localparam int SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
   localparam int SUM_W  = DIST_W + CNT_W;
   localparam int PROD_W = CFG_W + CNT_W;

   logic [DIST_W-1:0] ring_ff [AVG_DEPTH];
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PROD_W-1:0] limit;

   always_comb begin
      sum_in   = sum_ff - SUM_W'(ring_ff[slot_ff]) + SUM_W'(distance);
      slot_in  = (slot_ff == SLOT_W'(AVG_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
      count_in = (count_ff < CNT_W'(AVG_DEPTH)) ? count_ff + 1'b1 : count_ff;
      limit    = PROD_W'(threshold) * PROD_W'(count_in);
      below    = PROD_W'(sum_in) < limit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         slot_ff  <= '0;
         count_ff <= '0;
         for (int i = 0; i < AVG_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
      end else if (update) begin
         sum_ff           <= sum_in;
         slot_ff          <= slot_in;
         count_ff         <= count_in;
         ring_ff[slot_ff] <= distance;
      end
   end

endmodule

// ----- rtl/core/sumo_robot_behavior_fsm.sv -----
// Top level of the sumo robot behaviour controller.
// One tick is accepted per clock cycle. Each tick is held in an input register, then the mode
// decision, timer checks and filter update run combinationally into the result register. The
// controller state registers update together with the result register, which sets the
// throughput of one tick per cycle. A full result register that is not taken stalls
// the input register; the input side keeps accepting while the result register can drain.
module sumo_robot_behavior_fsm #(
   parameter int AVG_DEPTH = sbf_pkg::AVG_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [sbf_pkg::CFG_IDX_W-1:0]      csr_index,
   input  logic [sbf_pkg::CFG_W-1:0]          csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [sbf_pkg::DIST_W-1:0]         req_enemy_distance,
   input  logic                               req_edge_front,
   input  logic                               req_edge_back,
   input  logic [sbf_pkg::TIME_W-1:0]         req_now_ms,
   input  logic                               req_start_pressed,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [sbf_pkg::MODE_W-1:0]         rsp_mode,
   output logic                               rsp_mode_changed,
   output logic signed [sbf_pkg::DRIVE_W-1:0] rsp_left_drive,
   output logic signed [sbf_pkg::DRIVE_W-1:0] rsp_right_drive
);
   import sbf_pkg::*;

   logic [CFG_W-1:0] idle_time_ff, escape_time_ff, attack_dist_ff;

   logic              in_valid_ff;
   logic [DIST_W-1:0] in_dist_ff;
   logic              in_front_ff, in_back_ff, in_start_ff;
   logic [TIME_W-1:0] in_now_ff;

   logic              started_ff, started_in;
   logic [TIME_W-1:0] start_stamp_ff, start_stamp_in;
   logic              esc_front_ff, esc_front_in;
   logic              esc_back_ff, esc_back_in;
   logic [TIME_W-1:0] esc_stamp_ff, esc_stamp_in;
   logic [MODE_W-1:0] last_mode_ff;

   logic                      out_valid_ff;
   logic [MODE_W-1:0]         out_mode_ff;
   logic                      out_changed_ff;
   logic signed [DRIVE_W-1:0] out_left_ff, out_right_ff;

   logic                      out_free, advance;
   logic [MODE_W-1:0]         mode_in;
   logic signed [DRIVE_W-1:0] left_in, right_in;
   logic [TIME_W-1:0]         idle_el, esc_el;
   logic                      filter_update, filter_below;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   sbf_avg_filter #(
      .AVG_DEPTH (AVG_DEPTH)
   ) u_filter (
      .clock     (clock),
      .reset     (reset),
      .update    (advance && filter_update),
      .distance  (in_dist_ff),
      .threshold (attack_dist_ff),
      .below     (filter_below)
   );

   always_comb begin
      started_in     = started_ff;
      start_stamp_in = start_stamp_ff;
      esc_front_in   = esc_front_ff;
      esc_back_in    = esc_back_ff;
      esc_stamp_in   = esc_stamp_ff;
      mode_in        = MODE_IDLE;
      filter_update  = 1'b0;
      if (!started_ff && in_start_ff) begin
         started_in     = 1'b1;
         start_stamp_in = in_now_ff;
      end
      idle_el = in_now_ff - start_stamp_in;
      esc_el  = in_now_ff - esc_stamp_ff;
      if (started_in) begin
         priority if (idle_el < TIME_W'(idle_time_ff)) begin
            mode_in = MODE_IDLE;
         end else if (esc_front_ff && esc_el < TIME_W'(escape_time_ff)) begin
            mode_in = MODE_ESC_FRONT;
         end else if (esc_back_ff && esc_el < TIME_W'(escape_time_ff)) begin
            mode_in = MODE_ESC_BACK;
         end else begin
            esc_front_in = 1'b0;
            esc_back_in  = 1'b0;
            priority if (in_front_ff) begin
               esc_stamp_in = in_now_ff;
               esc_front_in = 1'b1;
               mode_in      = MODE_ESC_FRONT;
            end else if (in_back_ff) begin
               esc_stamp_in = in_now_ff;
               esc_back_in  = 1'b1;
               mode_in      = MODE_ESC_BACK;
            end else begin
               filter_update = 1'b1;
               mode_in       = filter_below ? MODE_ATTACK : MODE_SEARCH;
            end
         end
      end
   end

   always_comb begin
      unique case (mode_in)
         MODE_SEARCH: begin
            left_in  = DRIVE_SLOW_FWD;
            right_in = DRIVE_SLOW_REV;
         end
         MODE_ATTACK, MODE_ESC_BACK: begin
            left_in  = DRIVE_FULL_FWD;
            right_in = DRIVE_FULL_FWD;
         end
         MODE_ESC_FRONT: begin
            left_in  = DRIVE_FULL_REV;
            right_in = DRIVE_FULL_REV;
         end
         default: begin
            left_in  = DRIVE_ZERO;
            right_in = DRIVE_ZERO;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_time_ff   <= IDLE_TIME_RST;
         escape_time_ff <= ESCAPE_TIME_RST;
         attack_dist_ff <= ATTACK_DIST_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CFG_IDLE_TIME:   idle_time_ff   <= csr_wdata;
            CFG_ESCAPE_TIME: escape_time_ff <= csr_wdata;
            CFG_ATTACK_DIST: attack_dist_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_dist_ff  <= req_enemy_distance;
         in_front_ff <= req_edge_front;
         in_back_ff  <= req_edge_back;
         in_now_ff   <= req_now_ms;
         in_start_ff <= req_start_pressed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff     <= 1'b0;
         start_stamp_ff <= '0;
         esc_front_ff   <= 1'b0;
         esc_back_ff    <= 1'b0;
         esc_stamp_ff   <= '0;
         last_mode_ff   <= MODE_IDLE;
      end else if (advance) begin
         started_ff     <= started_in;
         start_stamp_ff <= start_stamp_in;
         esc_front_ff   <= esc_front_in;
         esc_back_ff    <= esc_back_in;
         esc_stamp_ff   <= esc_stamp_in;
         last_mode_ff   <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_mode_ff    <= mode_in;
         out_changed_ff <= (mode_in != last_mode_ff);
         out_left_ff    <= left_in;
         out_right_ff   <= right_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_mode         = out_mode_ff;
   assign rsp_mode_changed = out_changed_ff;
   assign rsp_left_drive   = out_left_ff;
   assign rsp_right_drive  = out_right_ff;

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the sumo robot behaviour controller.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sbf_pkg::*;

   localparam int                   AVG_DEPTH   = AVG_DEPTH_DEF;
   localparam int                   SUM_W       = 19;
   localparam int                   CYCLE_LIMIT = 200000;
   localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;
   localparam logic [TIME_W-1:0]    PRESS_MS    = 32'hFFFF_FF80;

   typedef struct {
      logic [MODE_W-1:0]         mode;
      logic                      changed;
      logic signed [DRIVE_W-1:0] left_drive;
      logic signed [DRIVE_W-1:0] right_drive;
   } mode_beat_type;

   logic                      clock;
   logic                      reset              = 1'b1;
   logic                      csr_we             = 1'b0;
   logic [CFG_IDX_W-1:0]      csr_index          = '0;
   logic [CFG_W-1:0]          csr_wdata          = '0;
   logic                      req_valid          = 1'b0;
   logic                      req_ready;
   logic [DIST_W-1:0]         req_enemy_distance = '0;
   logic                      req_edge_front     = 1'b0;
   logic                      req_edge_back      = 1'b0;
   logic [TIME_W-1:0]         req_now_ms         = '0;
   logic                      req_start_pressed  = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready          = 1'b0;
   logic [MODE_W-1:0]         rsp_mode;
   logic                      rsp_mode_changed;
   logic signed [DRIVE_W-1:0] rsp_left_drive;
   logic signed [DRIVE_W-1:0] rsp_right_drive;

   mode_beat_type expected_modes[$];
   int         err_count     = 0;
   int         cycle_count   = 0;
   int         send_idle_pct = 0;
   int         rsp_stall_pct = 0;
   logic [TIME_W-1:0] tick_ms = '0;

   logic [CFG_W-1:0]  cfg_idle_ms   = IDLE_TIME_RST;
   logic [CFG_W-1:0]  cfg_escape_ms = ESCAPE_TIME_RST;
   logic [CFG_W-1:0]  cfg_attack    = ATTACK_DIST_RST;

   logic              bot_started      = 1'b0;
   logic [TIME_W-1:0] bot_start_stamp  = '0;
   logic              bot_esc_front    = 1'b0;
   logic              bot_esc_back     = 1'b0;
   logic [TIME_W-1:0] bot_escape_stamp = '0;
   logic [MODE_W-1:0] bot_last_mode    = MODE_IDLE;
   logic [DIST_W-1:0] bot_ring[AVG_DEPTH] = '{default: '0};
   logic [SUM_W-1:0]  bot_sum          = '0;
   logic [2:0]        bot_slot         = '0;
   logic [2:0]        bot_count        = '0;

   sumo_robot_behavior_fsm u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_enemy_distance (req_enemy_distance),
      .req_edge_front     (req_edge_front),
      .req_edge_back      (req_edge_back),
      .req_now_ms         (req_now_ms),
      .req_start_pressed  (req_start_pressed),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_mode           (rsp_mode),
      .rsp_mode_changed   (rsp_mode_changed),
      .rsp_left_drive     (rsp_left_drive),
      .rsp_right_drive    (rsp_right_drive)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic predict_tick(input logic [DIST_W-1:0] distance, input logic ef, input logic eb,
                               input logic [TIME_W-1:0] now, input logic sp);
      logic [MODE_W-1:0] m;
      logic [TIME_W-1:0] since_start;
      logic [TIME_W-1:0] since_escape;
      logic [2:0]        slot;
      logic [35:0]       bar;
      mode_beat_type     r;
      m = MODE_IDLE;
      if (!bot_started && sp) begin
         bot_started     = 1'b1;
         bot_start_stamp = now;
      end
      since_start  = now - bot_start_stamp;
      since_escape = now - bot_escape_stamp;
      if (bot_started) begin
         if (since_start < TIME_W'(cfg_idle_ms)) begin
            m = MODE_IDLE;
         end else if (bot_esc_front && since_escape < TIME_W'(cfg_escape_ms)) begin
            m = MODE_ESC_FRONT;
         end else if (bot_esc_back && since_escape < TIME_W'(cfg_escape_ms)) begin
            m = MODE_ESC_BACK;
         end else begin
            bot_esc_front = 1'b0;
            bot_esc_back  = 1'b0;
            if (ef) begin
               bot_escape_stamp = now;
               bot_esc_front    = 1'b1;
               m                = MODE_ESC_FRONT;
            end else if (eb) begin
               bot_escape_stamp = now;
               bot_esc_back     = 1'b1;
               m                = MODE_ESC_BACK;
            end else begin
               slot           = (bot_slot < AVG_DEPTH) ? bot_slot : 3'd0;
               bot_sum        = bot_sum - SUM_W'(bot_ring[slot]) + SUM_W'(distance);
               bot_ring[slot] = distance;
               bot_slot       = (slot + 1 >= AVG_DEPTH) ? 3'd0 : slot + 3'd1;
               if (bot_count < AVG_DEPTH) bot_count = bot_count + 3'd1;
               bar = 36'(cfg_attack) * 36'(bot_count);
               m   = (36'(bot_sum) < bar) ? MODE_ATTACK : MODE_SEARCH;
            end
         end
      end
      case (m)
         MODE_SEARCH: begin
            r.left_drive  = DRIVE_SLOW_FWD;
            r.right_drive = DRIVE_SLOW_REV;
         end
         MODE_ATTACK, MODE_ESC_BACK: begin
            r.left_drive  = DRIVE_FULL_FWD;
            r.right_drive = DRIVE_FULL_FWD;
         end
         MODE_ESC_FRONT: begin
            r.left_drive  = DRIVE_FULL_REV;
            r.right_drive = DRIVE_FULL_REV;
         end
         default: begin
            r.left_drive  = DRIVE_ZERO;
            r.right_drive = DRIVE_ZERO;
         end
      endcase
      r.mode        = m;
      r.changed     = (m != bot_last_mode);
      bot_last_mode = m;
      expected_modes.push_back(r);
   endtask

   task automatic send_tick(input logic [DIST_W-1:0] distance, input logic ef, input logic eb,
                            input logic [TIME_W-1:0] now, input logic sp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_enemy_distance <= distance;
      req_edge_front     <= ef;
      req_edge_back      <= eb;
      req_now_ms         <= now;
      req_start_pressed  <= sp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_tick(distance, ef, eb, now, sp);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (expected_modes.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val,
                            input bit last);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CFG_IDLE_TIME:   cfg_idle_ms   = val;
         CFG_ESCAPE_TIME: cfg_escape_ms = val;
         CFG_ATTACK_DIST: cfg_attack    = val;
         default: ;
      endcase
      @(posedge clock);
      if (last) csr_we <= 1'b0;
   endtask

   task automatic set_config(input logic [CFG_W-1:0] idle, input logic [CFG_W-1:0] esc,
                             input logic [CFG_W-1:0] atk);
      write_reg(CFG_UNUSED, CFG_W'($urandom), 1'b0);
      write_reg(CFG_IDLE_TIME, idle, 1'b0);
      write_reg(CFG_ESCAPE_TIME, esc, 1'b0);
      write_reg(CFG_ATTACK_DIST, atk, 1'b1);
   endtask

   task automatic random_bouts(input int n);
      logic [DIST_W-1:0] distance;
      int unsigned       roll;
      repeat (n) begin
         roll = $urandom_range(99);
         if (roll < 5) begin
            send_tick(DIST_W'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
                      $urandom, 1'($urandom_range(1)));
         end else begin
            if (roll < 9)
               tick_ms = bot_start_stamp + TIME_W'(cfg_idle_ms) - 32'd3 + $urandom_range(0, 5);
            else if (roll < 13)
               tick_ms = bot_escape_stamp + TIME_W'(cfg_escape_ms) - 32'd2
                         + $urandom_range(0, 3);
            else if ($urandom_range(3) == 0)
               tick_ms = tick_ms + $urandom_range(0, 3000);
            else
               tick_ms = tick_ms + $urandom_range(0, 40);
            case ($urandom_range(3))
               0: distance = DIST_W'($urandom);
               1: distance = cfg_attack + DIST_W'($urandom_range(0, 64)) - 16'd32;
               2: distance = DIST_W'($urandom_range(0, 2 * int'(cfg_attack)));
               default: distance = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            endcase
            send_tick(distance, $urandom_range(99) < 6, $urandom_range(99) < 6, tick_ms,
                      1'($urandom_range(1)));
         end
      end
   endtask

   task automatic test_before_start;
      send_tick(16'h0000, 1'b1, 1'b1, 32'h0000_0000, 1'b0);
      send_tick(16'hFFFF, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0);
      send_tick(16'h1234, 1'b0, 1'b1, 32'h8000_0000, 1'b0);
      drain;
      write_reg(CFG_IDLE_TIME, 16'd0, 1'b1);
   endtask

   task automatic test_press_and_warmup;
      send_tick(16'd100, 1'b0, 1'b0, PRESS_MS, 1'b1);
      send_tick(16'hFFFF, 1'b0, 1'b0, PRESS_MS + 32'd10, 1'b0);
      send_tick(16'd0, 1'b0, 1'b0, PRESS_MS + 32'd20, 1'b1);
      send_tick(16'd0, 1'b0, 1'b0, PRESS_MS + 32'd30, 1'b0);
      send_tick(16'd0, 1'b0, 1'b0, PRESS_MS + 32'd40, 1'b0);
      send_tick(16'd0, 1'b0, 1'b0, PRESS_MS + 32'd50, 1'b0);
      send_tick(16'd0, 1'b0, 1'b0, PRESS_MS + 32'd60, 1'b0);
   endtask

   task automatic test_escape;
      send_tick(16'd0, 1'b1, 1'b1, PRESS_MS + 32'd100, 1'b0);
      send_tick(16'd0, 1'b0, 1'b0, PRESS_MS + 32'd399, 1'b0);
      send_tick(16'd0, 1'b0, 1'b1, PRESS_MS + 32'd400, 1'b0);
      send_tick(16'd0, 1'b1, 1'b0, PRESS_MS + 32'd699, 1'b0);
      send_tick(16'd300, 1'b0, 1'b0, PRESS_MS + 32'd700, 1'b0);
      send_tick(16'hFFFF, 1'b1, 1'b0, PRESS_MS + 32'd700, 1'b0);
   endtask

   task automatic test_thresholds;
      drain;
      set_config(16'd0, 16'd0, 16'd0);
      send_tick(16'd0, 1'b0, 1'b0, PRESS_MS + 32'd800, 1'b0);
      send_tick(16'd0, 1'b1, 1'b1, PRESS_MS + 32'd800, 1'b0);
      send_tick(16'd0, 1'b0, 1'b1, PRESS_MS + 32'd800, 1'b0);
      send_tick(16'd0, 1'b0, 1'b0, PRESS_MS + 32'd801, 1'b0);
   endtask

   task automatic test_idle_hold;
      drain;
      set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_tick(16'hFFFF, 1'b1, 1'b0, PRESS_MS + 32'd900, 1'b0);
      send_tick(16'hFFFF, 1'b0, 1'b0, PRESS_MS + 32'd65534, 1'b0);
      send_tick(16'hFFFF, 1'b0, 1'b0, PRESS_MS + 32'd65535, 1'b0);
      send_tick(16'd1, 1'b1, 1'b0, PRESS_MS + 32'd65536, 1'b0);
      send_tick(16'd0, 1'b0, 1'b1, PRESS_MS + 32'd131070, 1'b0);
      send_tick(16'd0, 1'b0, 1'b0, PRESS_MS + 32'd131071, 1'b0);
   endtask

   task automatic test_random_phase(input int send_pct, input int stall_pct,
                                    input logic [CFG_W-1:0] idle, input logic [CFG_W-1:0] esc,
                                    input logic [CFG_W-1:0] atk, input int n);
      drain;
      set_config(idle, esc, atk);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      random_bouts(n);
   endtask

   always @(posedge clock) begin : rsp_check
      mode_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_modes.size() == 0) begin
            $error("rsp beat with no tick outstanding: mode %0d", rsp_mode);
            err_count++;
         end else begin
            want = expected_modes.pop_front();
            if (rsp_mode !== want.mode) begin
               $error("mode: expected %0d, got %0d", want.mode, rsp_mode);
               err_count++;
            end
            if (rsp_mode_changed !== want.changed) begin
               $error("mode_changed: expected %0d, got %0d", want.changed, rsp_mode_changed);
               err_count++;
            end
            if (rsp_left_drive !== want.left_drive) begin
               $error("left_drive: expected %0d, got %0d", want.left_drive, rsp_left_drive);
               err_count++;
            end
            if (rsp_right_drive !== want.right_drive) begin
               $error("right_drive: expected %0d, got %0d", want.right_drive, rsp_right_drive);
               err_count++;
            end
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_before_start;
      test_press_and_warmup;
      test_escape;
      test_thresholds;
      test_idle_hold;
      test_random_phase(0, 0, 16'd0, 16'd300, 16'd320, 230);
      test_random_phase(55, 0, 16'd0, 16'd0, 16'd0, 230);
      test_random_phase(0, 55, 16'hFFFF, 16'hFFFF, 16'hFFFF, 230);
      test_random_phase(12, 12, CFG_W'($urandom_range(0, 3000)),
                        CFG_W'($urandom_range(0, 1500)), CFG_W'($urandom), 230);
      test_random_phase(0, 0, CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), 230);
      test_random_phase(12, 12, 16'd100, 16'hFFFF, 16'hFFFF, 230);
      drain;
      if (err_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/sbf_pkg.sv
rtl/core/sbf_avg_filter.sv
rtl/core/sumo_robot_behavior_fsm.sv
tb/sv/testbench.sv
